FILE: hdl/tbcr_pkg.sv
// ----------------------------------------------------------------------------
// Tile-map box collision resolver: shared definitions
// Widths, codes and types shared by the resolver's top, sequencer and collision unit.
// ----------------------------------------------------------------------------
package tbcr_pkg;

  // Solid-cell map geometry.
  localparam int MapDepth = 4096;
  localparam int AddrW    = 12;

  // Field widths of the request and configuration ports.
  localparam int CoordW = 24;
  localparam int HalfW  = 16;
  localparam int EdgeW  = 16;
  localparam int GridW  = 7;
  localparam int CfgIdxW = 2;

  // Internal positions are doubled coordinates (units of 1/512). Tile centres
  // stay below 2^25 in magnitude for sides up to 256, and a push lands at a
  // centre plus or minus the summed half size, so 28 signed bits suffice.
  localparam int PosW  = 28;
  localparam int DiffW = PosW + 1;
  localparam int SumW  = 18;

  typedef logic signed [PosW-1:0] pos_t;

  // Request kinds.
  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegGridWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTileEdge   = 2'd2;

  // Control from the sequencer to the collision unit.
  typedef struct packed {
    logic load;  // capture a new box at query acceptance
    logic eval;  // a visited cell that lies inside the map is at the unit
  } push_ctrl_t;

endpackage

FILE: hdl/tilemap_box_collision_resolver.sv
// ----------------------------------------------------------------------------
// Tile-map box collision resolver
// Keeps a solid-cell map of a tile grid centred on the origin and pushes a
// box out of every solid tile it overlaps, visiting cells in row-major order.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-cell map clear, one cell per cycle,
// and holds busy high until the sweep ends. A write request gives no result
// and leaves busy low. A query on a W by H grid keeps busy high while the
// shared multiplier sets the first row and column centres, while the cells
// pass one per cycle through the map read port and the collision unit, and
// during a drain and an output state; an empty grid skips to the latter. The
// result then appears on out_x_o and out_y_o with result_valid_o for exactly
// one cycle, and the receiver cannot hold it off. Configuration writes are
// always taken and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module tilemap_box_collision_resolver import tbcr_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [AddrW-1:0]   cell_index_i,
  input  logic               solid_bit_i,
  input  logic [CoordW-1:0]  box_x_i,
  input  logic [CoordW-1:0]  box_y_i,
  input  logic [HalfW-1:0]   box_half_i,
  // Result channel
  output logic               result_valid_o,
  output logic [CoordW-1:0]  out_x_o,
  output logic [CoordW-1:0]  out_y_o,
  // Configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [EdgeW-1:0]   cfg_data_i
);

  // Floor halving and saturation to signed Q15.8.
  function automatic logic [CoordW-1:0] sat_half(pos_t p2);
    pos_t q;
    q = p2 >>> 1;
    if (q > pos_t'(8388607)) begin
      q = pos_t'(8388607);
    end else if (q < pos_t'(-8388608)) begin
      q = pos_t'(-8388608);
    end
    return q[CoordW-1:0];
  endfunction

  logic [GridW-1:0] grid_width_q, grid_height_q;
  logic [EdgeW-1:0] tile_edge_q;

  logic             accept, query, map_we, clear, finish, solid;
  logic [AddrW-1:0] map_waddr, scan_addr;
  push_ctrl_t       push_ctrl;
  pos_t             cx, cy, px, py;

  logic              result_valid_q;
  logic [CoordW-1:0] out_x_q, out_y_q;

  assign accept      = start && !busy;
  assign query       = accept && (kind_i == KindQuery);
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridW'(1);
      grid_height_q <= GridW'(1);
      tile_edge_q   <= EdgeW'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegGridWidth:  grid_width_q  <= cfg_data_i[GridW-1:0];
        RegGridHeight: grid_height_q <= cfg_data_i[GridW-1:0];
        RegTileEdge:   tile_edge_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer.
  tbcr_seq #(
    .MaxSide(MAX_SIDE)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .query_i      (query),
    .grid_width_i (grid_width_q),
    .grid_height_i(grid_height_q),
    .tile_i       (tile_edge_q),
    .busy_o       (busy),
    .clear_o      (clear),
    .addr_o       (scan_addr),
    .push_o       (push_ctrl),
    .cx_o         (cx),
    .cy_o         (cy),
    .finish_o     (finish)
  );

  // The map write port serves the clearing sweep and write requests.
  assign map_we    = clear || (accept && (kind_i == KindWrite));
  assign map_waddr = clear ? scan_addr : cell_index_i;

  tbcr_ram #(
    .Width(1),
    .Depth(MapDepth)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(solid_bit_i && !clear),
    .raddr_i(scan_addr),
    .rdata_o(solid)
  );

  // Collision unit.
  tbcr_push_unit u_push (
    .clk_i     (clk_i),
    .ctrl_i    (push_ctrl),
    .solid_i   (solid),
    .box_x_i   (box_x_i),
    .box_y_i   (box_y_i),
    .box_half_i(box_half_i),
    .tile_i    (tile_edge_q),
    .cx_i      (cx),
    .cy_i      (cy),
    .px_o      (px),
    .py_o      (py)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_x_q <= sat_half(px);
      out_y_q <= sat_half(py);
    end
  end

  assign result_valid_o = result_valid_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;

endmodule

FILE: hdl/tbcr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tbcr_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/tbcr_push_unit.sv
// ----------------------------------------------------------------------------
// Tile-map box collision resolver: collision unit
// Holds the box position and tests it against one tile per cycle, pushing
// the box out along the axis of smaller overlap.
// ----------------------------------------------------------------------------
module tbcr_push_unit import tbcr_pkg::*; (
  input  logic              clk_i,
  input  push_ctrl_t        ctrl_i,
  input  logic              solid_i,
  input  logic [CoordW-1:0] box_x_i,
  input  logic [CoordW-1:0] box_y_i,
  input  logic [HalfW-1:0]  box_half_i,
  input  logic [EdgeW-1:0]  tile_i,
  input  pos_t              cx_i,
  input  pos_t              cy_i,
  output pos_t              px_o,
  output pos_t              py_o
);

  pos_t            px_q, px_d, py_q, py_d;
  logic [SumW-1:0] sum2_q, sum2_d;

  logic signed [DiffW-1:0] dx, dy;
  logic [DiffW-1:0]        adx, ady, sum_ext;
  pos_t                    sum_s;
  logic                    hit, push_x;

  // Centre differences and their magnitudes.
  assign dx      = DiffW'(px_q) - DiffW'(cx_i);
  assign dy      = DiffW'(py_q) - DiffW'(cy_i);
  assign adx     = dx[DiffW-1] ? -dx : dx;
  assign ady     = dy[DiffW-1] ? -dy : dy;
  assign sum_ext = DiffW'(sum2_q);
  assign sum_s   = pos_t'(sum2_q);

  // Overlap is strictly positive on both axes when both distances are below
  // the summed half size; the larger distance has the smaller overlap.
  assign hit    = ctrl_i.eval && solid_i && (adx < sum_ext) && (ady < sum_ext);
  assign push_x = adx > ady;

  // A push places the box exactly at the tile edge it was pushed from.
  always_comb begin
    px_d   = px_q;
    py_d   = py_q;
    sum2_d = sum2_q;
    if (ctrl_i.load) begin
      px_d   = {{(PosW-CoordW-1){box_x_i[CoordW-1]}}, box_x_i, 1'b0};
      py_d   = {{(PosW-CoordW-1){box_y_i[CoordW-1]}}, box_y_i, 1'b0};
      sum2_d = SumW'(tile_i) + SumW'({box_half_i, 1'b0});
    end else if (hit) begin
      if (push_x) begin
        px_d = dx[DiffW-1] ? (cx_i - sum_s) : (cx_i + sum_s);
      end else begin
        py_d = dy[DiffW-1] ? (cy_i - sum_s) : (cy_i + sum_s);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    sum2_q <= sum2_d;
  end

  assign px_o = px_q;
  assign py_o = py_q;

endmodule

FILE: hdl/tbcr_seq.sv
// ----------------------------------------------------------------------------
// Tile-map box collision resolver: sequencer
// Clears the map after reset, sets up the tile centres of a query with one
// shared multiplier and walks the grid one cell per cycle.
// ----------------------------------------------------------------------------
module tbcr_seq import tbcr_pkg::*; #(
  parameter int MaxSide = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             query_i,
  input  logic [GridW-1:0] grid_width_i,
  input  logic [GridW-1:0] grid_height_i,
  input  logic [EdgeW-1:0] tile_i,
  output logic             busy_o,
  output logic             clear_o,
  output logic [AddrW-1:0] addr_o,
  output push_ctrl_t       push_o,
  output pos_t             cx_o,
  output pos_t             cy_o,
  output logic             finish_o
);

  localparam int SideW = $clog2(MaxSide + 1);
  localparam int CellW = $clog2(MaxSide * MaxSide);
  localparam int IdxW  = (CellW > AddrW) ? CellW : AddrW;
  localparam int ProdW = SideW + EdgeW;

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StMulY   = 3'd2;
  localparam logic [2:0] StMulX   = 3'd3;
  localparam logic [2:0] StScan   = 3'd4;
  localparam logic [2:0] StDrain  = 3'd5;
  localparam logic [2:0] StFinish = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [SideW-1:0] col_q, col_d, row_q, row_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  pos_t             cx0_q, cx0_d, cx_q, cx_d, cy_q, cy_d;
  logic             ev_valid_q, ev_valid_d, ev_inmap_q, ev_inmap_d;
  pos_t             ev_cx_q, ev_cx_d, ev_cy_q, ev_cy_d;

  logic [SideW-1:0] width, height, mul_a;
  logic [ProdW-1:0] prod;
  pos_t             step;
  logic             last_col, last_row;

  // Sides above the supported maximum saturate.
  assign width  = (32'(grid_width_i) > MaxSide) ? SideW'(MaxSide) : SideW'(grid_width_i);
  assign height = (32'(grid_height_i) > MaxSide) ? SideW'(MaxSide) : SideW'(grid_height_i);

  // Shared multiplier for the first row and column centres.
  assign mul_a = (state_q == StMulY) ? (height - SideW'(1)) : (width - SideW'(1));
  assign prod  = ProdW'(mul_a) * ProdW'(tile_i);
  assign step  = pos_t'({tile_i, 1'b0});

  assign last_col = (col_q == width - SideW'(1));
  assign last_row = (row_q == height - SideW'(1));

  // Next-state logic.
  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    idx_d      = idx_q;
    cx0_d      = cx0_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    ev_valid_d = 1'b0;
    ev_inmap_d = ev_inmap_q;
    ev_cx_d    = ev_cx_q;
    ev_cy_d    = ev_cy_q;
    unique case (state_q)
      StClear: begin
        idx_d = idx_q + IdxW'(1);
        if (idx_q[AddrW-1:0] == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (query_i) begin
          if (width == '0 || height == '0) begin
            state_d = StFinish;
          end else begin
            state_d = StMulY;
          end
        end
      end
      StMulY: begin
        cy_d    = pos_t'(prod);
        state_d = StMulX;
      end
      StMulX: begin
        cx0_d   = pos_t'(0) - pos_t'(prod);
        cx_d    = pos_t'(0) - pos_t'(prod);
        col_d   = '0;
        row_d   = '0;
        idx_d   = '0;
        state_d = StScan;
      end
      StScan: begin
        // Hand the current cell to the evaluation stage.
        ev_valid_d = 1'b1;
        ev_inmap_d = ((idx_q >> AddrW) == '0);
        ev_cx_d    = cx_q;
        ev_cy_d    = cy_q;
        idx_d      = idx_q + IdxW'(1);
        if (last_col) begin
          col_d = '0;
          row_d = row_q + SideW'(1);
          cx_d  = cx0_q;
          cy_d  = cy_q - step;
          if (last_row) begin
            state_d = StDrain;
          end
        end else begin
          col_d = col_q + SideW'(1);
          cx_d  = cx_q + step;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      col_q      <= '0;
      row_q      <= '0;
      idx_q      <= '0;
      ev_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      idx_q      <= idx_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  // Centre registers.
  always_ff @(posedge clk_i) begin
    cx0_q      <= cx0_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    ev_inmap_q <= ev_inmap_d;
    ev_cx_q    <= ev_cx_d;
    ev_cy_q    <= ev_cy_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign clear_o     = (state_q == StClear);
  assign addr_o      = idx_q[AddrW-1:0];
  assign push_o.load = (state_q == StIdle) && query_i;
  assign push_o.eval = ev_valid_q && ev_inmap_q;
  assign cx_o        = ev_cx_q;
  assign cy_o        = ev_cy_q;
  assign finish_o    = (state_q == StFinish);

endmodule
